// ===== rtl/stt_pkg.sv =====
// Package for the sorted task table: field widths, event codes, key helpers.
// No dependencies.
`default_nettype none
package stt_pkg;
  localparam int unsigned DAY_W = 22;
  localparam int unsigned ID_W  = 16;
  localparam int unsigned ROW_W = 6;
  localparam int unsigned KEY_W = 35;

  typedef enum logic [2:0] {
    EV_NONE    = 3'd0,
    EV_INSERT  = 3'd1,
    EV_MOVE    = 3'd2,
    EV_CHANGE  = 3'd3,
    EV_REMOVE  = 3'd4,
    EV_FULL    = 3'd5,
    EV_READ    = 3'd6,
    EV_READ_OOR = 3'd7
  } event_t;

  typedef enum logic {
    OP_UPSERT = 1'b0,
    OP_READ   = 1'b1
  } op_t;

  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [DAY_W-1:0] start_day;
    logic [DAY_W-1:0] end_day;
    logic             end_valid;
  } entry_t;

  // Broadcast from the controller to every cell.
  typedef enum logic [1:0] {
    CMD_HOLD   = 2'd0,
    CMD_SHIFT_DOWN = 2'd1,  // rows at or past pos take from the row above
    CMD_SHIFT_UP   = 2'd2,  // rows at or past pos take from the row below
    CMD_WRITE  = 2'd3       // row pos takes the broadcast entry
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_SCAN, ST_DECIDE, ST_SHIFT, ST_PLACE, ST_OUT
  } state_t;

  // Urgency key: class in the top 3 bits, 32-bit day count below.
  function automatic logic [KEY_W-1:0] urgency(input logic [DAY_W-1:0] st,
      input logic [DAY_W-1:0] en, input logic ev, input logic [DAY_W-1:0] t);
    logic [2:0]  cls;
    logic [31:0] days;
    logic [31:0] d_en;
    logic [31:0] d_st;
    d_en = {10'd0, en} - {10'd0, t};
    d_st = {10'd0, st} - {10'd0, t};
    if (ev) begin
      if (en < t) begin
        cls = 3'd0; days = d_en;
      end else if (en == t) begin
        cls = 3'd1; days = '0;
      end else if (st <= t) begin
        cls = 3'd2; days = d_en;
      end else begin
        cls = 3'd4; days = d_st;
      end
    end else begin
      if (st <= t) begin
        cls = 3'd3; days = '0;
      end else begin
        cls = 3'd4; days = d_st;
      end
    end
    return {cls, days};
  endfunction
endpackage
`default_nettype wire

// ===== rtl/stt_if.sv =====
// Valid/ready channel interface carrying one payload type.
// Depends on nothing; the payload type is a parameter.
`default_nettype none
interface stt_if #(parameter type T = logic) (input wire logic clk);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/sorted_task_table_upsert.sv =====
// Top level of the sorted task table: controller and a chain of DEPTH cells.
// Depends on stt_pkg, stt_if and stt_cell.
//
//  channel | dir | payload
//  in_ch   | in  | operation, entry_id, start_day, end_day, end_valid, is_active, row_index
//  out_ch  | out | event_kind, row_from, row_to, read_id, read_start, read_end, read_end_valid
//  cfg     | in  | today_day (cfg_we, cfg_data)
//
// After acceptance a request waits in the scan state while the registered compares
// settle, then decides, then shifts and writes the chain and raises out_ch.valid.
// Reads, rejected inserts and removes of unknown ids skip the chain; a remove shifts,
// a change writes, an insert shifts then writes, a move shifts, shifts down, writes.
// The next transfer can be taken in the cycle out_ch.valid rises; a stalled result
// holds the following item in its decide step. Reset clears the entry count and
// control; cell contents are not reset.
`default_nettype none
module sorted_task_table_upsert #(
  parameter int unsigned DEPTH = 64
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic cfg_we,
  input  wire logic [stt_pkg::DAY_W-1:0] cfg_data,
  stt_if.sink   in_ch,
  stt_if.source out_ch
);
  import stt_pkg::*;

  localparam int unsigned IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  typedef struct packed {
    logic            operation;
    logic [ID_W-1:0] entry_id;
    logic [DAY_W-1:0] start_day;
    logic [DAY_W-1:0] end_day;
    logic            end_valid;
    logic            is_active;
    logic [ROW_W-1:0] row_index;
  } in_t;

  typedef struct packed {
    logic [2:0]       event_kind;
    logic [ROW_W-1:0] row_from;
    logic [ROW_W-1:0] row_to;
    logic [ID_W-1:0]  read_id;
    logic [DAY_W-1:0] read_start;
    logic [DAY_W-1:0] read_end;
    logic             read_end_valid;
  } out_t;

  logic [DAY_W-1:0] today;
  state_t state, state_next;
  logic [1:0] wait_cnt;
  in_t req;
  logic [KEY_W-1:0] req_key;
  logic [CW-1:0] count;
  logic [IW-1:0] dst, pos;
  logic move;
  cmd_t cmd;
  entry_t bcast;
  entry_t ents [DEPTH];
  logic [KEY_W-1:0] keys [DEPTH];
  logic [DEPTH-1:0] hit, gt;
  out_t res;
  logic out_valid;
  logic res_free;
  out_t res_next;
  logic move_next;
  logic [IW-1:0] pos_next, dst_next;
  logic rd_in_range;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) today <= '0;
    else if (cfg_we) today <= cfg_data;
  end

  assign bcast = '{id: req.entry_id, start_day: req.start_day,
                   end_day: req.end_day, end_valid: req.end_valid};

  // Cell chain.
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    entry_t above, below;
    if (g == 0) begin : g_top
      assign above = bcast;
    end else begin : g_mid
      assign above = ents[g-1];
    end
    if (g == DEPTH - 1) begin : g_bot
      assign below = bcast;
    end else begin : g_low
      assign below = ents[g+1];
    end
    stt_cell u_cell (
      .clk(clk), .cmd(cmd),
      .sel_shift(IW'(g) >= pos), .sel_write(IW'(g) == pos),
      .bcast(bcast), .from_above(above), .from_below(below),
      .today(today), .probe_key(req_key),
      .entry(ents[g]), .key(keys[g]), .id_hit(hit[g]), .key_gt(gt[g])
    );
  end

  // First valid row with a hit, and first valid row with a greater key.
  logic [IW-1:0] first_hit, first_gt;
  logic any_hit, any_gt;
  always_comb begin
    first_hit = '0; any_hit = 1'b0;
    first_gt  = '0; any_gt  = 1'b0;
    for (int i = DEPTH - 1; i >= 0; i--) begin
      if (hit[i] && (CW'(i) < count)) begin
        first_hit = IW'(i); any_hit = 1'b1;
      end
      if (gt[i] && (CW'(i) < count)) begin
        first_gt = IW'(i); any_gt = 1'b1;
      end
    end
  end

  // Insert position, which may equal the entry count.
  logic [CW-1:0] d_pos;
  assign d_pos = any_gt ? CW'(first_gt) : count;

  // The known entry must move when its new key breaks the order with a neighbor.
  function automatic logic up_d(input logic [IW-1:0] s);
    logic u, d;
    u = (s != '0) && (req_key < keys[s - 1'b1]);
    d = (CW'(s) + 1'b1 < count) && (keys[s + 1'b1] < req_key);
    return u || d;
  endfunction

  assign dst_next    = IW'((d_pos > CW'(first_hit)) ? d_pos - 1'b1 : d_pos);
  assign rd_in_range = (32'(req.row_index) < 32'(count));
  assign res_free    = !out_valid || out_ch.ready;

  // Result and placement, decided from the settled compare flags.
  always_comb begin
    res_next  = '0;
    move_next = 1'b0;
    pos_next  = first_hit;
    if (req.operation == OP_READ) begin
      res_next.row_from = req.row_index;
      if (rd_in_range) begin
        res_next.event_kind     = EV_READ;
        res_next.read_id        = ents[IW'(req.row_index)].id;
        res_next.read_start     = ents[IW'(req.row_index)].start_day;
        res_next.read_end       = ents[IW'(req.row_index)].end_day;
        res_next.read_end_valid = ents[IW'(req.row_index)].end_valid;
      end else begin
        res_next.event_kind = EV_READ_OOR;
      end
    end else if (req.is_active) begin
      if (any_hit) begin
        move_next = up_d(first_hit);
        res_next.row_from = ROW_W'(first_hit);
        if (move_next) begin
          res_next.event_kind = EV_MOVE;
          res_next.row_to     = ROW_W'(dst_next);
        end else begin
          res_next.event_kind = EV_CHANGE;
          res_next.row_to     = ROW_W'(first_hit);
        end
      end else if (count == CW'(DEPTH)) begin
        res_next.event_kind = EV_FULL;
      end else begin
        pos_next = IW'(d_pos);
        res_next.event_kind = EV_INSERT;
        res_next.row_to     = ROW_W'(d_pos);
      end
    end else if (any_hit) begin
      res_next.event_kind = EV_REMOVE;
      res_next.row_from   = ROW_W'(first_hit);
    end
  end

  assign in_ch.ready  = (state == ST_IDLE);
  assign out_ch.valid = out_valid;
  assign out_ch.data  = res;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    cmd = CMD_HOLD;
    unique case (state)
      ST_IDLE:   if (in_ch.valid && in_ch.ready) state_next = ST_SCAN;
      ST_SCAN:   if (wait_cnt == 2'd2) state_next = ST_DECIDE;
      ST_DECIDE: if (res_free) state_next = ST_OUT;
      ST_SHIFT: begin
        cmd = (move || !req.is_active) ? CMD_SHIFT_UP : CMD_SHIFT_DOWN;
        state_next = (req.is_active) ? ST_PLACE : ST_OUT;
      end
      ST_PLACE: begin
        cmd = (move) ? CMD_SHIFT_DOWN : CMD_WRITE;
        state_next = (move) ? ST_PLACE : ST_OUT;
      end
      ST_OUT: begin
        state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
    if (state == ST_PLACE && !move) cmd = CMD_WRITE;
    if (state == ST_DECIDE && res_free && req.operation == OP_UPSERT) begin
      if (req.is_active && any_hit) state_next = move_next ? ST_SHIFT : ST_PLACE;
      else if (req.is_active && !any_hit && count != CW'(DEPTH)) state_next = ST_SHIFT;
      else if (!req.is_active && any_hit) state_next = ST_SHIFT;
    end
  end

  // Datapath of the controller.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0; out_valid <= 1'b0; wait_cnt <= '0;
    end else begin
      if (out_valid && out_ch.ready) out_valid <= 1'b0;
      case (state)
        ST_IDLE: begin
          wait_cnt <= '0;
          if (in_ch.valid && in_ch.ready) begin
            req <= in_ch.data;
            req_key <= urgency(in_ch.data.start_day, in_ch.data.end_day,
                               in_ch.data.end_valid, today);
          end
        end
        ST_SCAN: wait_cnt <= wait_cnt + 1'b1;
        ST_DECIDE: begin
          if (res_free) begin
            res  <= res_next;
            move <= move_next;
            pos  <= pos_next;
            dst  <= dst_next;
          end
        end
        ST_SHIFT: begin
          if (move) pos <= dst;  // then open a gap at dst and write
          else if (!req.is_active) count <= count - 1'b1;
          else count <= count + 1'b1;
        end
        ST_PLACE: begin
          if (move) move <= 1'b0;
        end
        ST_OUT: out_valid <= 1'b1;
        default: ;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_count: assert property (@(posedge clk) disable iff (rst) count <= CW'(DEPTH))
    else $error("entry count above depth");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ch.ready |=> out_valid && $stable(res))
    else $error("result changed while stalled");
  a_full: assert property (@(posedge clk) disable iff (rst)
    (count == CW'(DEPTH)) |=> (count == CW'(DEPTH)) || $past(state) == ST_SHIFT
    || $past(state) == ST_PLACE) else $error("count changed outside shift");
`endif
endmodule
`default_nettype wire

// ===== rtl/stt_cell.sv =====
// One table cell: holds one entry, its key, and compare flags for the search.
// Depends on stt_pkg.
`default_nettype none
module stt_cell (
  input  wire logic                clk,
  input  wire stt_pkg::cmd_t       cmd,
  input  wire logic                sel_shift,  // this row is at or past pos
  input  wire logic                sel_write,  // this row is pos
  input  wire stt_pkg::entry_t     bcast,
  input  wire stt_pkg::entry_t     from_above, // row i-1
  input  wire stt_pkg::entry_t     from_below, // row i+1
  input  wire logic [stt_pkg::DAY_W-1:0] today,
  input  wire logic [stt_pkg::KEY_W-1:0] probe_key,
  output stt_pkg::entry_t          entry,
  output logic [stt_pkg::KEY_W-1:0] key,
  output logic                     id_hit,
  output logic                     key_gt
);
  import stt_pkg::*;

  // Entry register: shifts with its neighbors or takes the broadcast.
  always_ff @(posedge clk) begin
    case (cmd)
      CMD_SHIFT_DOWN: if (sel_shift) entry <= from_above;
      CMD_SHIFT_UP:   if (sel_shift) entry <= from_below;
      CMD_WRITE:      if (sel_write) entry <= bcast;
      default: ;
    endcase
  end

  // Key and compare flags registered; key_gt compares against the registered key.
  always_ff @(posedge clk) begin
    key    <= urgency(entry.start_day, entry.end_day, entry.end_valid, today);
    id_hit <= (entry.id == bcast.id);
    key_gt <= (key > probe_key);
  end
endmodule
`default_nettype wire

// ===== tb/stt_tb_types.sv =====
// Transfer payload types for the sorted task table testbench.
// Depends on stt_pkg for widths and codes.
`timescale 1ns / 1ps
package stt_tb_types;
  import stt_pkg::*;

  typedef struct packed {
    op_t              operation;
    logic [ID_W-1:0]  entry_id;
    logic [DAY_W-1:0] start_day;
    logic [DAY_W-1:0] end_day;
    logic             end_valid;
    logic             is_active;
    logic [ROW_W-1:0] row_index;
  } request_t;

  typedef struct packed {
    event_t           event_kind;
    logic [ROW_W-1:0] row_from;
    logic [ROW_W-1:0] row_to;
    logic [ID_W-1:0]  read_id;
    logic [DAY_W-1:0] read_start;
    logic [DAY_W-1:0] read_end;
    logic             read_end_valid;
  } response_t;
endpackage

// ===== tb/task_table_checker.sv =====
// Checker for the sorted task table: mirrors the table, predicts each response, compares.
// Depends on stt_pkg, stt_tb_types and stt_if.
`timescale 1ns / 1ps
module task_table_checker #(
  parameter int unsigned DEPTH = 64
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic cfg_we,
  input  wire logic [stt_pkg::DAY_W-1:0] cfg_data,
  stt_if in_ch,
  stt_if out_ch,
  output int errors,
  output int pending
);
  import stt_pkg::*;
  import stt_tb_types::*;

  logic [DAY_W-1:0] today;
  entry_t           rows [DEPTH];
  int               row_count;
  response_t        expected_responses[$];

  assign pending = expected_responses.size();

  // Key: class in the top bits, day difference modulo 2^32 below.
  function automatic logic [KEY_W-1:0] task_key(entry_t e);
    logic [31:0] d_en;
    logic [31:0] d_st;
    d_en = {10'd0, e.end_day} - {10'd0, today};
    d_st = {10'd0, e.start_day} - {10'd0, today};
    if (e.end_valid) begin
      if (e.end_day < today) return {3'd0, d_en};
      if (e.end_day == today) return {3'd1, 32'd0};
      if (e.start_day <= today) return {3'd2, d_en};
      return {3'd4, d_st};
    end
    if (e.start_day <= today) return {3'd3, 32'd0};
    return {3'd4, d_st};
  endfunction

  // First row whose key is strictly greater, so equal keys stay ahead.
  function automatic int first_later_row(logic [KEY_W-1:0] k);
    for (int i = 0; i < row_count; i++)
      if (k < task_key(rows[i])) return i;
    return row_count;
  endfunction

  function automatic void erase_row(int s);
    for (int i = s; i + 1 < row_count; i++) rows[i] = rows[i + 1];
    row_count--;
  endfunction

  function automatic void insert_row(int p, entry_t e);
    for (int i = row_count; i > p; i--) rows[i] = rows[i - 1];
    rows[p] = e;
    row_count++;
  endfunction

  // Applies one request to the mirror table and returns its response.
  function automatic response_t apply_request(request_t rq);
    response_t   r;
    entry_t      e;
    logic [KEY_W-1:0] k;
    int          s;
    int          d;
    bit          moves;
    r = '0;
    if (rq.operation == OP_READ) begin
      r.row_from = rq.row_index;
      if (rq.row_index < row_count) begin
        r.event_kind     = EV_READ;
        r.read_id        = rows[rq.row_index].id;
        r.read_start     = rows[rq.row_index].start_day;
        r.read_end       = rows[rq.row_index].end_day;
        r.read_end_valid = rows[rq.row_index].end_valid;
      end else begin
        r.event_kind = EV_READ_OOR;
      end
      return r;
    end
    s = -1;
    for (int i = 0; i < row_count; i++)
      if (rows[i].id == rq.entry_id) begin
        s = i;
        break;
      end
    e = '{id: rq.entry_id, start_day: rq.start_day, end_day: rq.end_day,
          end_valid: rq.end_valid};
    k = task_key(e);
    if (!rq.is_active) begin
      if (s >= 0) begin
        erase_row(s);
        r.event_kind = EV_REMOVE;
        r.row_from   = s[ROW_W-1:0];
      end
    end else if (s < 0) begin
      if (row_count >= DEPTH) begin
        r.event_kind = EV_FULL;
      end else begin
        d = first_later_row(k);
        insert_row(d, e);
        r.event_kind = EV_INSERT;
        r.row_to     = d[ROW_W-1:0];
      end
    end else begin
      moves = (s > 0 && k < task_key(rows[s - 1])) ||
              (s + 1 < row_count && task_key(rows[s + 1]) < k);
      if (moves) begin
        d = first_later_row(k);
        if (d > s) d--;
        erase_row(s);
        insert_row(d, e);
        r.event_kind = EV_MOVE;
        r.row_to     = d[ROW_W-1:0];
      end else begin
        rows[s] = e;
        r.event_kind = EV_CHANGE;
        r.row_to     = s[ROW_W-1:0];
      end
      r.row_from = s[ROW_W-1:0];
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("%0t: mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
    errors++;
  endtask

  // Responses are compared before the same edge's request is predicted.
  always @(posedge clk) begin
    response_t got;
    response_t want;
    if (rst) begin
      today     <= '0;
      row_count = 0;
      errors    = 0;
      expected_responses.delete();
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got = out_ch.data;
        if (expected_responses.size() == 0) begin
          report_mismatch("unexpected response", 64'(got.event_kind), '0);
        end else begin
          want = expected_responses.pop_front();
          if (got.event_kind != want.event_kind)
            report_mismatch("event_kind", 64'(got.event_kind), 64'(want.event_kind));
          if (got.row_from != want.row_from)
            report_mismatch("row_from", 64'(got.row_from), 64'(want.row_from));
          if (got.row_to != want.row_to)
            report_mismatch("row_to", 64'(got.row_to), 64'(want.row_to));
          if (got.read_id != want.read_id)
            report_mismatch("read_id", 64'(got.read_id), 64'(want.read_id));
          if (got.read_start != want.read_start)
            report_mismatch("read_start", 64'(got.read_start), 64'(want.read_start));
          if (got.read_end != want.read_end)
            report_mismatch("read_end", 64'(got.read_end), 64'(want.read_end));
          if (got.read_end_valid != want.read_end_valid)
            report_mismatch("read_end_valid", 64'(got.read_end_valid),
                            64'(want.read_end_valid));
        end
      end
      if (in_ch.valid && in_ch.ready)
        expected_responses.push_back(apply_request(in_ch.data));
      if (cfg_we) today <= cfg_data;
    end
  end
endmodule

// ===== tb/sorted_task_table_upsert_tb.sv =====
// Testbench top for the sorted task table: clock, reset, stimulus and verdict.
// Depends on stt_pkg, stt_tb_types, stt_if, task_table_checker and the block.
`timescale 1ns / 1ps
module sorted_task_table_upsert_tb;
  import stt_pkg::*;
  import stt_tb_types::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SETTLE_CYCLES  = 16;
  localparam int PHASE_ITEMS    = 230;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [DAY_W-1:0] cfg_data = '0;
  logic [DAY_W-1:0] today_now = '0;
  int   errors;
  int   pending;
  int   idle_pct = 0;
  int   stall_pct = 0;
  int   quiet_cycles = 0;
  int   id_pool = 20;
  int   active_pct = 85;

  stt_if #(.T(request_t))  in_ch  (clk);
  stt_if #(.T(response_t)) out_ch (clk);

  sorted_task_table_upsert #(.DEPTH(64)) dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .in_ch(in_ch), .out_ch(out_ch)
  );

  task_table_checker #(.DEPTH(64)) u_checker (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .in_ch(in_ch), .out_ch(out_ch), .errors(errors), .pending(pending)
  );

  always #2 clk = ~clk;

  initial begin
    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    out_ch.ready = 1'b0;
  end

  // Receiver stalls at the rate of the current phase.
  always @(posedge clk) begin
    out_ch.ready <= (rst == 1'b0) && ($urandom_range(99) >= stall_pct);
  end

  // Watchdog on cycles with no transfer on either channel.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || rst)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Holds valid until the transfer; an idle gap drops valid first.
  task automatic send_request(request_t rq);
    if (in_ch.valid && $urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(6, 1)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= rq;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic drain_results();
    if (in_ch.valid) begin
      in_ch.valid <= 1'b0;
    end
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // The date register is only written while the table is idle.
  task automatic set_today(logic [DAY_W-1:0] day);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_data  <= day;
    today_now = day;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic request_t upsert(logic [ID_W-1:0] id, logic [DAY_W-1:0] st,
      logic [DAY_W-1:0] en, logic ev, logic act);
    request_t rq;
    rq = '0;
    rq.operation = OP_UPSERT;
    rq.entry_id  = id;
    rq.start_day = st;
    rq.end_day   = en;
    rq.end_valid = ev;
    rq.is_active = act;
    rq.row_index = ROW_W'($urandom);
    return rq;
  endfunction

  function automatic request_t read_row(logic [ROW_W-1:0] r);
    request_t rq;
    rq = '0;
    rq.operation = OP_READ;
    rq.row_index = r;
    rq.entry_id  = ID_W'($urandom);
    return rq;
  endfunction

  // Mostly days near the current date so that every urgency class shows up.
  function automatic logic [DAY_W-1:0] pick_day();
    if ($urandom_range(99) < 70)
      return today_now + DAY_W'($urandom_range(8)) - DAY_W'(4);
    return DAY_W'($urandom);
  endfunction

  function automatic request_t random_request();
    request_t rq;
    logic [ID_W-1:0] id;
    if ($urandom_range(99) < 20) return read_row(ROW_W'($urandom));
    id = ($urandom_range(99) < 90) ? ID_W'($urandom_range(id_pool)) : ID_W'($urandom);
    rq = upsert(id, pick_day(), pick_day(), 1'($urandom_range(1)),
                $urandom_range(99) < active_pct);
    rq.end_valid = 1'($urandom_range(1));
    return rq;
  endfunction

  initial begin
    logic [DAY_W-1:0] phase_days[5];
    phase_days = '{22'h3FFFFF, 22'd100, 22'd0, 22'h200000, 22'd77777};
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty reads, each urgency class, extremes, move, change, remove.
    set_today(22'd1000);
    send_request(read_row(6'd0));
    send_request(read_row(6'd63));
    send_request(upsert(16'd5, 22'd0, 22'd0, 1'b1, 1'b0));
    send_request(upsert(16'd0, 22'd10, 22'd999, 1'b1, 1'b1));
    send_request(upsert(16'hFFFF, 22'd10, 22'd1000, 1'b1, 1'b1));
    send_request(upsert(16'd1, 22'd900, 22'd1005, 1'b1, 1'b1));
    send_request(upsert(16'd2, 22'd900, 22'h3FFFFF, 1'b0, 1'b1));
    send_request(upsert(16'd3, 22'h3FFFFF, 22'h3FFFFF, 1'b1, 1'b1));
    send_request(upsert(16'd4, 22'd2000, 22'd0, 1'b0, 1'b1));
    send_request(upsert(16'd6, 22'd1000, 22'd0, 1'b0, 1'b1));
    send_request(upsert(16'd1, 22'd900, 22'd1006, 1'b1, 1'b1));
    send_request(upsert(16'd3, 22'd0, 22'd0, 1'b1, 1'b1));
    send_request(upsert(16'd0, 22'd10, 22'd1000, 1'b1, 1'b1));
    send_request(read_row(6'd0));
    send_request(read_row(6'd3));
    send_request(read_row(6'd7));
    send_request(upsert(16'd2, 22'd0, 22'd0, 1'b0, 1'b0));
    send_request(upsert(16'hFFFF, 22'd0, 22'd0, 1'b0, 1'b0));
    send_request(read_row(6'd1));
    // Changing the date leaves the stored order stale; rules apply as stored.
    set_today(22'd0);
    send_request(upsert(16'd4, 22'd5, 22'd0, 1'b0, 1'b1));
    send_request(read_row(6'd2));

    // Random phases: pool size sets how often the table fills and rejects.
    for (int ph = 0; ph < 5; ph++) begin
      set_today(phase_days[ph]);
      case (ph % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 48; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 48; end
        default: begin idle_pct = 6; stall_pct = 6; end
      endcase
      id_pool    = (ph % 2 == 0) ? 100 : 30;
      active_pct = (ph == 3) ? 40 : 85;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        send_request(random_request());
        // Sender holds off once until everything outstanding has come back.
        if (ph == 1 && n == PHASE_ITEMS / 2) drain_results();
      end
    end

    drain_results();
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
